>>> rtl/core/cscan_pkg.sv
package cscan_pkg;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_HEAD    = 2'd1,
    KIND_SWEEP   = 2'd2,
    KIND_WRAP    = 2'd3
  } cscan_kind_t;

  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HEAD_TRACK = 1'b0,
    REG_MAX_TRACK  = 1'b1
  } cscan_reg_t;

  localparam logic [31:0] MAX_TRACK_RESET = 32'd65535;

  typedef struct packed {
    logic rot;
    logic clr;
    logic tail;
  } cscan_cell_ctl_t;

endpackage

>>> rtl/core/cscan_if.sv
interface cscan_req_if #(parameter int TRACK_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] track;
  logic                  last;
  modport source (output valid, track, last, input ready);
  modport sink (input valid, track, last, output ready);
endinterface

interface cscan_visit_if #(parameter int TRACK_BITS = 16);
  logic                    valid;
  logic                    ready;
  logic [TRACK_BITS-1:0]   served_track;
  logic [1:0]              visit_kind;
  logic [TRACK_BITS+1:0]   total_movement;
  logic                    end_of_order;
  modport source (output valid, served_track, visit_kind, total_movement, end_of_order,
                  input ready);
  modport sink (input valid, served_track, visit_kind, total_movement, end_of_order,
                output ready);
endinterface

interface cscan_cfg_if #(parameter int TRACK_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic                  index;
  logic [TRACK_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/cscan_cell.sv
module cscan_cell
  import cscan_pkg::*;
#(
  parameter int TRACK_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cscan_cell_ctl_t       ctl,
  input  logic                  in_v,
  input  logic [TRACK_BITS-1:0] in_d,
  input  logic [TRACK_BITS-1:0] nbr_d,
  input  logic [TRACK_BITS-1:0] wrap_d,
  output logic [TRACK_BITS-1:0] val,
  output logic                  occ,
  output logic                  pass_v,
  output logic [TRACK_BITS-1:0] pass_d
);

  logic [TRACK_BITS-1:0] val_r, val_nxt;
  logic                  occ_r, occ_nxt;
  logic                  pass_v_r, pass_v_nxt;
  logic [TRACK_BITS-1:0] pass_d_r, pass_d_nxt;

  always_comb begin
    val_nxt    = val_r;
    occ_nxt    = occ_r;
    pass_v_nxt = 1'b0;
    pass_d_nxt = pass_d_r;
    if (ctl.clr) begin
      occ_nxt = 1'b0;
    end else if (ctl.rot) begin
      val_nxt = ctl.tail ? wrap_d : nbr_d;
    end else if (in_v) begin
      if (!occ_r) begin
        occ_nxt = 1'b1;
        val_nxt = in_d;
      end else if (in_d < val_r) begin
        val_nxt    = in_d;
        pass_v_nxt = 1'b1;
        pass_d_nxt = val_r;
      end else begin
        pass_v_nxt = 1'b1;
        pass_d_nxt = in_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= 1'b0;
      pass_v_r <= 1'b0;
    end else begin
      occ_r    <= occ_nxt;
      pass_v_r <= pass_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    pass_d_r <= pass_d_nxt;
  end

  assign val    = val_r;
  assign occ    = occ_r;
  assign pass_v = pass_v_r;
  assign pass_d = pass_d_r;

endmodule

>>> rtl/core/cscan_disk_scheduler_core.sv
// Load: one request per cycle; each request ripples one cell per cycle into a sorted chain.
// Order: after the last of n requests the chain settles, requests below head_track rotate
// to the back, then the head visit follows. Emit: one visit per cycle while the output is
// ready, n + 2 or n + 3 visits, with an idle slot when the sweep-end visit is skipped;
// no new request is taken until the final visit.
// Reset (synchronous, rst_n low): store empty, head_track 0, max_track 65535, output idle.
module cscan_disk_scheduler_core
  import cscan_pkg::*;
#(
  parameter int MAX_REQUESTS = 32,
  parameter int TRACK_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  cscan_req_if.sink           in_req,
  cscan_visit_if.source       out_visit,
  cscan_cfg_if.sink           cfg_wr
);

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int MW = TRACK_BITS + 2;

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_SETTLE = 8'b0000_0010,
    S_SKIP   = 8'b0000_0100,
    S_HEAD   = 8'b0000_1000,
    S_UPPER  = 8'b0001_0000,
    S_SWEEP  = 8'b0010_0000,
    S_WRAP   = 8'b0100_0000,
    S_LOWER  = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [TRACK_BITS-1:0] head_r, max_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         lo_r, lo_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [TRACK_BITS-1:0] pos_r, pos_nxt;
  logic [TRACK_BITS-1:0] top_r, top_nxt;
  logic [MW-1:0]         mov_r, mov_nxt;

  logic                  out_vld_r;
  logic [TRACK_BITS-1:0] out_trk_r, e_trk;
  cscan_kind_t           out_kind_r, e_kind;
  logic [MW-1:0]         out_mov_r;
  logic                  out_end_r, e_end;
  logic                  emit;

  logic [TRACK_BITS-1:0] val    [MAX_REQUESTS];
  logic [TRACK_BITS-1:0] pass_d [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] occ_vec, pass_vec;
  logic                  rot, clr;
  logic                  in_fire, ins_v, slot_ok;
  logic [TRACK_BITS-1:0] front;
  logic [TRACK_BITS-1:0] d_front, d_top;

  assign in_fire = in_req.valid && in_req.ready;
  assign ins_v   = in_fire && (cnt_r < CW'(MAX_REQUESTS));
  assign front   = val[0];
  assign slot_ok = !out_vld_r || out_visit.ready;
  assign d_front = (front > pos_r) ? (front - pos_r) : (pos_r - front);
  assign d_top   = (top_r > max_r) ? (top_r - max_r) : (max_r - top_r);

  assign in_req.ready = (state_r == S_LOAD);
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      max_r  <= TRACK_BITS'(MAX_TRACK_RESET);
    end else if (cfg_wr.valid) begin
      case (cscan_reg_t'(cfg_wr.index))
        REG_HEAD_TRACK: head_r <= cfg_wr.data;
        REG_MAX_TRACK:  max_r  <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_REQUESTS; gi++) begin : g_cell
      cscan_cell_ctl_t       ctl;
      logic                  c_in_v;
      logic [TRACK_BITS-1:0] c_in_d;
      logic [TRACK_BITS-1:0] c_nbr;
      assign ctl.rot  = rot;
      assign ctl.clr  = clr;
      assign ctl.tail = (cnt_r == CW'(gi + 1));
      if (gi == 0) begin : g_first
        assign c_in_v = ins_v;
        assign c_in_d = in_req.track;
      end else begin : g_rest
        assign c_in_v = pass_vec[gi-1];
        assign c_in_d = pass_d[gi-1];
      end
      if (gi == MAX_REQUESTS - 1) begin : g_end
        assign c_nbr = front;
      end else begin : g_mid
        assign c_nbr = val[gi+1];
      end
      cscan_cell #(.TRACK_BITS(TRACK_BITS)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .in_v   (c_in_v),
        .in_d   (c_in_d),
        .nbr_d  (c_nbr),
        .wrap_d (front),
        .val    (val[gi]),
        .occ    (occ_vec[gi]),
        .pass_v (pass_vec[gi]),
        .pass_d (pass_d[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lo_nxt    = lo_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    top_nxt   = top_r;
    mov_nxt   = mov_r;
    rot       = 1'b0;
    clr       = 1'b0;
    emit      = 1'b0;
    e_trk     = front;
    e_kind    = KIND_REQUEST;
    e_end     = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (ins_v) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (in_fire && in_req.last) begin
          state_nxt = S_SETTLE;
        end
      end
      S_SETTLE: begin
        if (!(|pass_vec)) begin
          lo_nxt    = '0;
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if ((lo_r < cnt_r) && (front < head_r)) begin
          rot    = 1'b1;
          lo_nxt = lo_r + CW'(1);
        end else begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (slot_ok) begin
          emit      = 1'b1;
          e_trk     = head_r;
          e_kind    = KIND_HEAD;
          mov_nxt   = '0;
          pos_nxt   = head_r;
          top_nxt   = head_r;
          idx_nxt   = '0;
          state_nxt = (lo_r == cnt_r) ? S_SWEEP : S_UPPER;
        end
      end
      S_UPPER: begin
        if (slot_ok) begin
          emit    = 1'b1;
          e_trk   = front;
          e_kind  = KIND_REQUEST;
          mov_nxt = mov_r + MW'(d_front);
          pos_nxt = front;
          top_nxt = front;
          rot     = 1'b1;
          idx_nxt = idx_r + CW'(1);
          if ((idx_r + lo_r + CW'(1)) == cnt_r) begin
            state_nxt = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (top_r == max_r) begin
          state_nxt = S_WRAP;
        end else if (slot_ok) begin
          emit      = 1'b1;
          e_trk     = max_r;
          e_kind    = KIND_SWEEP;
          mov_nxt   = mov_r + MW'(d_top);
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        if (slot_ok) begin
          emit    = 1'b1;
          e_trk   = '0;
          e_kind  = KIND_WRAP;
          e_end   = (lo_r == '0);
          mov_nxt = mov_r + MW'(max_r);
          pos_nxt = '0;
          idx_nxt = '0;
          if (lo_r == '0) begin
            clr       = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_LOWER;
          end
        end
      end
      S_LOWER: begin
        if (slot_ok) begin
          emit    = 1'b1;
          e_trk   = front;
          e_kind  = KIND_REQUEST;
          mov_nxt = mov_r + MW'(d_front);
          pos_nxt = front;
          idx_nxt = idx_r + CW'(1);
          if ((idx_r + CW'(1)) == lo_r) begin
            e_end     = 1'b1;
            clr       = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            rot = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      lo_r      <= '0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lo_r    <= lo_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_visit.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    top_r <= top_nxt;
    mov_r <= mov_nxt;
    if (emit) begin
      out_trk_r  <= e_trk;
      out_kind_r <= e_kind;
      out_mov_r  <= mov_nxt;
      out_end_r  <= e_end;
    end
  end

  assign out_visit.valid          = out_vld_r;
  assign out_visit.served_track   = out_trk_r;
  assign out_visit.visit_kind     = out_kind_r;
  assign out_visit.total_movement = out_mov_r;
  assign out_visit.end_of_order   = out_end_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_REQUESTS))
    else $error("request count above store depth");

  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SKIP) |-> ($countones(occ_vec) == int'(cnt_r)))
    else $error("occupied cells disagree with request count");

  a_end_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_end) |=> (state_r == S_LOAD && cnt_r == '0))
    else $error("final visit did not return to load");

  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_kind_r == KIND_HEAD) |-> (out_mov_r == '0))
    else $error("head visit with nonzero movement");
`endif

endmodule
